@@ rtl/ovq_pkg.sv @@
`default_nettype none

package ovq_pkg;

	localparam int DEPTH      = 64;
	localparam int STAMP_BITS = 32;

	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int ID_W       = 16;
	localparam int PORT_STAMP_W = 32;
	localparam int OP_W       = 2;
	localparam int KIND_W     = 3;
	localparam int CAP_W      = 7;
	localparam int POL_W      = 2;
	localparam int LFSR_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
	localparam logic [CAP_W-1:0]  CAP_RESET = 7'd16;

	// operation codes
	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
	localparam logic [OP_W-1:0] OP_DONE = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DISPATCHED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RETRY      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_COMPLETED  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NO_SERVICE = 3'd6;

	// overload policies
	localparam logic [POL_W-1:0] POL_BLOCK  = 2'd0;
	localparam logic [POL_W-1:0] POL_TAIL   = 2'd1;
	localparam logic [POL_W-1:0] POL_HEAD   = 2'd2;
	localparam logic [POL_W-1:0] POL_RANDOM = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [STAMP_BITS-1:0] stamp;
		logic                  mark;
	} entry_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_SHIFT,
		CM_ROTATE,
		CM_PUSH,
		CM_MARK
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t       mode;
		logic [CNT_W-1:0] last;
		logic [CNT_W-1:0] target;
	} cell_ctl_t;

	// clamp capacity into 1..DEPTH
	function automatic logic [CNT_W-1:0] cap_limit(input logic [CAP_W-1:0] cap);
		int c;
		c = int'(cap);
		if (c == 0)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		return CNT_W'(c);
	endfunction

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] n;
		n = s >> 1;
		if (s[0])
			n = n ^ LFSR_MASK;
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ovq_if.sv @@
`default_nettype none

interface ovq_req_if;
	logic                             valid;
	logic                             ready;
	logic [ovq_pkg::OP_W-1:0]         op;
	logic [ovq_pkg::ID_W-1:0]         request_id;
	logic [ovq_pkg::PORT_STAMP_W-1:0] arrival_stamp;

	modport source (output valid, op, request_id, arrival_stamp, input ready);
	modport sink   (input valid, op, request_id, arrival_stamp, output ready);
endinterface

interface ovq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ovq_pkg::KIND_W-1:0]       kind;
	logic [ovq_pkg::ID_W-1:0]         out_id;
	logic [ovq_pkg::PORT_STAMP_W-1:0] out_stamp;
	logic                             last;

	modport source (output valid, kind, out_id, out_stamp, last, input ready);
	modport sink   (input valid, kind, out_id, out_stamp, last, output ready);
endinterface

`default_nettype wire

@@ rtl/ovq_cell.sv @@
`default_nettype none

module ovq_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ovq_pkg::cell_ctl_t         ctl,
	input  wire logic [ovq_pkg::IDX_W-1:0]  index,
	input  wire ovq_pkg::entry_t            nxt,
	input  wire ovq_pkg::entry_t            head,
	input  wire ovq_pkg::entry_t            din,
	output ovq_pkg::entry_t                 q
);

	logic [ovq_pkg::CNT_W-1:0]      pos;
	logic [ovq_pkg::ID_W-1:0]       id_q;
	logic [ovq_pkg::STAMP_BITS-1:0] stamp_q;
	logic                           mark_q;
	ovq_pkg::entry_t                cur;
	ovq_pkg::entry_t                nd;

	assign pos = ovq_pkg::CNT_W'(index);
	assign cur = '{id: id_q, stamp: stamp_q, mark: mark_q};
	assign q   = cur;

	always_comb begin
		nd = cur;
		case (ctl.mode)
			ovq_pkg::CM_SHIFT: begin
				// move toward the head; the vacated tail slot loses its mark
				if (pos < ctl.last)
					nd = nxt;
				else if (pos == ctl.last)
					nd.mark = 1'b0;
			end
			ovq_pkg::CM_ROTATE: begin
				if (pos < ctl.last)
					nd = nxt;
				else if (pos == ctl.last) begin
					nd      = head;
					nd.mark = 1'b0;
				end
			end
			ovq_pkg::CM_PUSH: begin
				if (pos == ctl.target) begin
					nd      = din;
					nd.mark = 1'b0;
				end
			end
			ovq_pkg::CM_MARK: begin
				if (pos == ctl.target)
					nd.mark = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		id_q    <= nd.id;
		stamp_q <= nd.stamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mark_q <= 1'b0;
		else
			mark_q <= nd.mark;
	end

endmodule

`default_nettype wire

@@ rtl/ovq_rem.sv @@
`default_nettype none

module ovq_rem (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ovq_pkg::LFSR_W-1:0]  dividend,
	input  wire logic [ovq_pkg::CNT_W-1:0]   divisor,
	output logic                             done,
	output logic [ovq_pkg::CNT_W-1:0]        rem
);

	localparam int STEP_W = $clog2(ovq_pkg::LFSR_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             cnt_q;
	logic [ovq_pkg::LFSR_W-1:0]    dvd_q;
	logic [ovq_pkg::CNT_W-1:0]     dsr_q;
	logic [ovq_pkg::CNT_W-1:0]     rem_q;
	logic [ovq_pkg::CNT_W:0]       trial;
	logic [ovq_pkg::CNT_W:0]       diff;
	logic [ovq_pkg::CNT_W-1:0]     rem_n;

	// one restoring step per cycle, dividend msb first
	assign trial = {rem_q, dvd_q[ovq_pkg::LFSR_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign rem_n = (trial >= {1'b0, dsr_q}) ? diff[ovq_pkg::CNT_W-1:0]
	                                         : trial[ovq_pkg::CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(ovq_pkg::LFSR_W);
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_n;
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dsr_q)
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/overload_request_queue_unit.sv @@
`default_nettype none

// Overload request queue: admission queue of pending requests (id and arrival
// stamp) plus a count of requests in service, capped by the capacity register.
//
// Channels: req (sink) carries op, request_id and arrival_stamp; rsp (source)
// returns one or more results per transaction, the final one flagged by last.
// cfg_we/cfg_index/cfg_wdata write capacity, overload policy and LFSR seed;
// write only while the queue is idle.
//
// Timing: req.ready is high while the controller is idle. An ordinary
// transaction runs an accept and a decide step; its result is registered
// and shows on rsp in the cycle after the decide cycle. Drop head adds a
// further accept step. Random drop repeats draws (LFSR step, 16 remainder
// steps plus done, mark check) until ceil(pending/4) entries are marked,
// then walks the cell chain once and accepts the new id.
// Reset clears counts, marks and the control state; stored entries are not
// cleared. When rsp stalls, the output register holds its result and the
// controller waits on any step that produces a further result.
module overload_request_queue_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ovq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ovq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	ovq_req_if.sink                              req,
	ovq_rsp_if.source                            rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_ACCEPT,
		S_DRAW,
		S_MOD,
		S_MARK,
		S_COMPACT
	} state_t;

	state_t                              state_q, state_n;

	// configuration
	logic [ovq_pkg::CAP_W-1:0]           cap_q;
	logic [ovq_pkg::POL_W-1:0]           policy_q;
	logic [ovq_pkg::LFSR_W-1:0]          random_state_q, lfsr_n;

	// held transaction
	logic [ovq_pkg::OP_W-1:0]            op_q;
	logic [ovq_pkg::ID_W-1:0]            id_q;
	logic [ovq_pkg::STAMP_BITS-1:0]      stamp_q;

	// counts
	logic [ovq_pkg::CNT_W-1:0]           pend_q, pend_n;
	logic [ovq_pkg::CNT_W-1:0]           serv_q, serv_n;
	logic [ovq_pkg::CNT_W-1:0]           chosen_q, chosen_n;
	logic [ovq_pkg::CNT_W-1:0]           k_q, k_n;
	logic [ovq_pkg::CNT_W-1:0]           steps_q, steps_n;

	// output register
	logic                                out_valid_q;
	logic [ovq_pkg::KIND_W-1:0]          out_kind_q;
	logic [ovq_pkg::ID_W-1:0]            out_id_q;
	logic [ovq_pkg::PORT_STAMP_W-1:0]    out_stamp_q;
	logic                                out_last_q;
	logic                                out_free;

	logic                                emit;
	logic [ovq_pkg::KIND_W-1:0]          e_kind;
	logic [ovq_pkg::ID_W-1:0]            e_id;
	logic [ovq_pkg::PORT_STAMP_W-1:0]    e_stamp;
	logic                                e_last;

	// cell chain
	ovq_pkg::cell_ctl_t                  cell_ctl;
	ovq_pkg::entry_t                     cell_q [ovq_pkg::DEPTH];
	ovq_pkg::entry_t                     new_entry;
	logic [ovq_pkg::DEPTH-1:0]           mark_vec;

	logic                                full;
	logic                                rem_start;
	logic                                rem_done;
	logic [ovq_pkg::CNT_W-1:0]           rem;

	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = ({1'b0, pend_q} + {1'b0, serv_q})
	                   >= {1'b0, ovq_pkg::cap_limit(cap_q)};
	assign new_entry = '{id: id_q, stamp: stamp_q, mark: 1'b0};

	for (genvar g = 0; g < ovq_pkg::DEPTH; g++) begin : g_cell
		ovq_pkg::entry_t nxt;
		if (g == ovq_pkg::DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_q[g+1];
		end
		ovq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.index  (ovq_pkg::IDX_W'(g)),
			.nxt    (nxt),
			.head   (cell_q[0]),
			.din    (new_entry),
			.q      (cell_q[g])
		);
		assign mark_vec[g] = cell_q[g].mark;
	end

	ovq_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (lfsr_n),
		.divisor  (pend_q),
		.done     (rem_done),
		.rem      (rem)
	);

	always_comb begin
		state_n   = state_q;
		cell_ctl  = '{mode: ovq_pkg::CM_HOLD, last: pend_q - 1'b1, target: pend_q};
		emit      = 1'b0;
		e_kind    = ovq_pkg::KIND_ACCEPTED;
		e_id      = id_q;
		e_stamp   = '0;
		e_last    = 1'b1;
		pend_n    = pend_q;
		serv_n    = serv_q;
		lfsr_n    = random_state_q;
		chosen_n  = chosen_q;
		k_n       = k_q;
		steps_n   = steps_q;
		rem_start = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid)
					state_n = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_free) begin
					state_n = S_IDLE;
					case (op_q)
						ovq_pkg::OP_ENQ: begin
							emit = 1'b1;
							if (!full) begin
								cell_ctl.mode = ovq_pkg::CM_PUSH;
								pend_n        = pend_q + 1'b1;
							end else if (policy_q == ovq_pkg::POL_BLOCK) begin
								e_kind = ovq_pkg::KIND_RETRY;
							end else if (policy_q == ovq_pkg::POL_TAIL || pend_q == '0) begin
								e_kind = ovq_pkg::KIND_DROPPED;
							end else if (policy_q == ovq_pkg::POL_HEAD) begin
								// drop the oldest, then accept in the next step
								e_kind        = ovq_pkg::KIND_DROPPED;
								e_id          = cell_q[0].id;
								e_last        = 1'b0;
								cell_ctl.mode = ovq_pkg::CM_SHIFT;
								pend_n        = pend_q - 1'b1;
								state_n       = S_ACCEPT;
							end else begin
								emit     = 1'b0;
								k_n      = ovq_pkg::CNT_W'(({1'b0, pend_q}
								           + (ovq_pkg::CNT_W + 1)'(3)) >> 2);
								chosen_n = '0;
								state_n  = S_DRAW;
							end
						end
						ovq_pkg::OP_DEQ: begin
							emit = 1'b1;
							if (pend_q == '0) begin
								e_kind = ovq_pkg::KIND_EMPTY;
								e_id   = '0;
							end else begin
								e_kind        = ovq_pkg::KIND_DISPATCHED;
								e_id          = cell_q[0].id;
								e_stamp       = ovq_pkg::PORT_STAMP_W'(cell_q[0].stamp);
								cell_ctl.mode = ovq_pkg::CM_SHIFT;
								pend_n        = pend_q - 1'b1;
								serv_n        = serv_q + 1'b1;
							end
						end
						ovq_pkg::OP_DONE: begin
							emit = 1'b1;
							if (serv_q == '0) begin
								e_kind = ovq_pkg::KIND_NO_SERVICE;
							end else begin
								e_kind = ovq_pkg::KIND_COMPLETED;
								serv_n = serv_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_ACCEPT: begin
				if (out_free) begin
					emit          = 1'b1;
					cell_ctl.mode = ovq_pkg::CM_PUSH;
					pend_n        = pend_q + 1'b1;
					state_n       = S_IDLE;
				end
			end
			S_DRAW: begin
				lfsr_n    = ovq_pkg::lfsr_step(random_state_q);
				rem_start = 1'b1;
				state_n   = S_MOD;
			end
			S_MOD: begin
				if (rem_done)
					state_n = S_MARK;
			end
			S_MARK: begin
				state_n = S_DRAW;
				// a marked entry is drawn again
				if (!mark_vec[rem[ovq_pkg::IDX_W-1:0]]) begin
					cell_ctl.mode   = ovq_pkg::CM_MARK;
					cell_ctl.target = rem;
					chosen_n        = chosen_q + 1'b1;
					if (chosen_n == k_q) begin
						steps_n = pend_q;
						state_n = S_COMPACT;
					end
				end
			end
			S_COMPACT: begin
				// each step retires the head: drop it if marked, else rotate to tail
				if (cell_q[0].mark) begin
					if (out_free) begin
						emit          = 1'b1;
						e_kind        = ovq_pkg::KIND_DROPPED;
						e_id          = cell_q[0].id;
						e_last        = 1'b0;
						cell_ctl.mode = ovq_pkg::CM_SHIFT;
						pend_n        = pend_q - 1'b1;
						steps_n       = steps_q - 1'b1;
						if (steps_q == ovq_pkg::CNT_W'(1))
							state_n = S_ACCEPT;
					end
				end else begin
					cell_ctl.mode = ovq_pkg::CM_ROTATE;
					steps_n       = steps_q - 1'b1;
					if (steps_q == ovq_pkg::CNT_W'(1))
						state_n = S_ACCEPT;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cap_q          <= ovq_pkg::CAP_RESET;
			policy_q       <= ovq_pkg::POL_BLOCK;
			random_state_q <= ovq_pkg::LFSR_W'(1);
			op_q           <= '0;
			id_q           <= '0;
			stamp_q        <= '0;
			pend_q         <= '0;
			serv_q         <= '0;
			chosen_q       <= '0;
			k_q            <= '0;
			steps_q        <= '0;
			out_valid_q    <= 1'b0;
			out_kind_q     <= '0;
			out_id_q       <= '0;
			out_stamp_q    <= '0;
			out_last_q     <= 1'b0;
		end else begin
			state_q        <= state_n;
			pend_q         <= pend_n;
			serv_q         <= serv_n;
			chosen_q       <= chosen_n;
			k_q            <= k_n;
			steps_q        <= steps_n;

			// capture the transaction
			if (state_q == S_IDLE && req.valid) begin
				op_q    <= req.op;
				id_q    <= req.request_id;
				stamp_q <= ovq_pkg::STAMP_BITS'(req.arrival_stamp);
			end

			// output register: load a result, else drop it once taken
			if (emit) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= e_kind;
				out_id_q    <= e_id;
				out_stamp_q <= e_stamp;
				out_last_q  <= e_last;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// a seed write loads the LFSR, else advance it on a draw
			if (cfg_we && cfg_index == ovq_pkg::REG_SEED) begin
				// a zero seed would lock the LFSR
				if (cfg_wdata[ovq_pkg::LFSR_W-1:0] == '0)
					random_state_q <= ovq_pkg::LFSR_W'(1);
				else
					random_state_q <= cfg_wdata[ovq_pkg::LFSR_W-1:0];
			end else begin
				random_state_q <= lfsr_n;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					ovq_pkg::REG_CAPACITY: cap_q <= cfg_wdata[ovq_pkg::CAP_W-1:0];
					ovq_pkg::REG_POLICY:   policy_q <= cfg_wdata[ovq_pkg::POL_W-1:0];
					ovq_pkg::REG_SEED:     ;
					default: ;
				endcase
			end
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.kind      = out_kind_q;
	assign rsp.out_id    = out_id_q;
	assign rsp.out_stamp = out_stamp_q;
	assign rsp.last      = out_last_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= ovq_pkg::CNT_W'(ovq_pkg::DEPTH))
		else $error("pending count beyond depth");

	a_marks_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> mark_vec == '0)
		else $error("drop marks left set after a transaction");

	a_marks_match_chosen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAW || state_q == S_MOD || state_q == S_MARK)
		|-> $countones(mark_vec) == int'(chosen_q))
		else $error("drop marks disagree with chosen count");

endmodule

`default_nettype wire
